>>> hw/rtl/kte_pkg.sv
// Package for the multi-tap keypad text entry decoder.
// Holds the key, request and mode codes, the item and result types and the letter tables.
// No dependencies.
`default_nettype none

package kte_pkg;

  localparam int unsigned TextCapacityDef = 128;
  localparam logic [31:0] TimeoutReset    = 32'd1000;

  typedef enum logic {
    REQ_KEY     = 1'b0,
    REQ_TIMEOUT = 1'b1
  } req_e;

  typedef enum logic [3:0] {
    KEY_BKSP     = 4'd10,
    KEY_CASE     = 4'd11,
    KEY_RETURN   = 4'd12,
    KEY_ASTERISK = 4'd13,
    KEY_POUND    = 4'd14,
    KEY_OTHER    = 4'd15
  } key_e;

  typedef enum logic [1:0] {
    MODE_UPPER = 2'd0,
    MODE_LOWER = 2'd1,
    MODE_NUM   = 2'd2
  } mode_e;

  localparam logic [7:0] ChNewline = 8'h0a;
  localparam logic [7:0] ChStar    = 8'h2a;
  localparam logic [7:0] ChHash    = 8'h23;
  localparam logic [7:0] ChSpace   = 8'h20;
  localparam logic [7:0] ChZero    = 8'h30;
  localparam logic [7:0] ChOne     = 8'h31;
  localparam logic [7:0] CaseGap   = 8'h20;

  typedef struct packed {
    logic        req_type;
    logic [3:0]  key_code;
    logic [31:0] tick_now;
  } kte_item_t;

  typedef struct packed {
    logic [1:0] append_count;
    logic [7:0] first_char;
    logic [7:0] second_char;
    logic       erase_last;
    logic       pending_valid;
    logic [7:0] pending_char;
    logic [1:0] input_mode;
    logic [7:0] text_length;
  } kte_result_t;

  // number of letters on a letter key, 0 for other keys
  function automatic logic [2:0] kte_count(input logic [3:0] digit);
    logic [2:0] n;
    case (digit)
      4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd8: n = 3'd3;
      4'd7, 4'd9:                          n = 3'd4;
      default:                             n = 3'd0;
    endcase
    return n;
  endfunction

  function automatic logic [7:0] kte_letter(input logic [3:0] digit, input logic [1:0] idx,
                                            input logic upper);
    logic [7:0] base;
    logic [1:0] sel;
    logic [7:0] ch;
    case (digit)
      4'd2:    base = 8'h61;
      4'd3:    base = 8'h64;
      4'd4:    base = 8'h67;
      4'd5:    base = 8'h6a;
      4'd6:    base = 8'h6d;
      4'd7:    base = 8'h70;
      4'd8:    base = 8'h74;
      4'd9:    base = 8'h77;
      default: base = 8'h00;
    endcase
    sel = ({1'b0, idx} >= kte_count(digit)) ? 2'd0 : idx;
    ch  = base + {6'd0, sel};
    if (base == 8'h00) begin
      ch = 8'h00;
    end else if (upper) begin
      ch = ch - CaseGap;
    end
    return ch;
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/kte_if.sv
// Channel interfaces of the keypad decoder: key item in, status result out, timeout write.
// Valid/ready handshake; no package dependency.
`default_nettype none

interface kte_in_if;
  logic        valid;
  logic        ready;
  logic        req_type;
  logic [3:0]  key_code;
  logic [31:0] tick_now;
  modport source (output valid, req_type, key_code, tick_now, input ready);
  modport sink   (input valid, req_type, key_code, tick_now, output ready);
endinterface

interface kte_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] append_count;
  logic [7:0] first_char;
  logic [7:0] second_char;
  logic       erase_last;
  logic       pending_valid;
  logic [7:0] pending_char;
  logic [1:0] input_mode;
  logic [7:0] text_length;
  modport source (output valid, append_count, first_char, second_char, erase_last,
                  pending_valid, pending_char, input_mode, text_length, input ready);
  modport sink   (input valid, append_count, first_char, second_char, erase_last,
                  pending_valid, pending_char, input_mode, text_length, output ready);
endinterface

interface kte_cfg_if;
  logic        valid;
  logic        ready;
  logic [31:0] timeout_ticks;
  modport source (output valid, timeout_ticks, input ready);
  modport sink   (input valid, timeout_ticks, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/multi_tap_keypad_text_entry.sv
// Top level of the multi-tap keypad text entry decoder: input register, decoder, result register.
// Depends on kte_pkg, kte_if and kte_decode.
//
//   channel  dir  payload                                          transfer
//   in_ch    in   req_type, key_code, tick_now                     valid && ready
//   out_ch   out  append_count .. text_length (status per item)    valid && ready
//   cfg_ch   in   timeout_ticks                                    valid && ready
//
// One item per cycle while out_ch is ready; an item goes from the input to the result register.
// The decoder state updates in the same cycle as the result register loads.
// A stalled result holds the result register; the input register keeps taking an item
// until it is full too. Reset clears state, mode, length and sets timeout_ticks to 1000.
`default_nettype none

module multi_tap_keypad_text_entry #(
  parameter int unsigned TEXT_CAPACITY = kte_pkg::TextCapacityDef
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  kte_in_if.sink    in_ch,
  kte_out_if.source out_ch,
  kte_cfg_if.sink   cfg_ch
);
  import kte_pkg::*;

  logic        in_vld_q;
  kte_item_t   in_q;
  logic        out_vld_q;
  kte_result_t out_q;
  kte_result_t res;
  logic [31:0] timeout_q;
  logic        adv;

  assign adv         = in_vld_q && (!out_vld_q || out_ch.ready);
  assign in_ch.ready = !in_vld_q || adv;
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      timeout_q <= TimeoutReset;
    end else begin
      if (in_ch.ready) begin
        in_vld_q <= in_ch.valid;
      end
      if (adv) begin
        out_vld_q <= 1'b1;
      end else if (out_ch.ready) begin
        out_vld_q <= 1'b0;
      end
      if (cfg_ch.valid) begin
        timeout_q <= cfg_ch.timeout_ticks;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ch.valid && in_ch.ready) begin
      in_q.req_type <= in_ch.req_type;
      in_q.key_code <= in_ch.key_code;
      in_q.tick_now <= in_ch.tick_now;
    end
    if (adv) begin
      out_q <= res;
    end
  end

  kte_decode #(
    .TEXT_CAPACITY(TEXT_CAPACITY)
  ) u_decode (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .adv_i     (adv),
    .item_i    (in_q),
    .timeout_i (timeout_q),
    .res_o     (res)
  );

  assign out_ch.valid         = out_vld_q;
  assign out_ch.append_count  = out_q.append_count;
  assign out_ch.first_char    = out_q.first_char;
  assign out_ch.second_char   = out_q.second_char;
  assign out_ch.erase_last    = out_q.erase_last;
  assign out_ch.pending_valid = out_q.pending_valid;
  assign out_ch.pending_char  = out_q.pending_char;
  assign out_ch.input_mode    = out_q.input_mode;
  assign out_ch.text_length   = out_q.text_length;

  a_erase_no_append: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && out_q.erase_last |-> out_q.append_count == 2'd0)
    else $error("erase reported together with an append");

  a_pending_char: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> (out_q.pending_valid == (out_q.pending_char != 8'h00)))
    else $error("pending flag and pending character disagree");

  a_ready_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ch.ready |-> in_vld_q && out_vld_q)
    else $error("input stalled with room in the pipeline");

  a_result_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv |=> out_vld_q)
    else $error("decoded item did not reach the result register");

endmodule

`default_nettype wire

>>> hw/rtl/kte_decode.sv
// Decoder state and single-pass next-state logic for one registered key item.
// Depends on kte_pkg.
`default_nettype none

module kte_decode #(
  parameter int unsigned TEXT_CAPACITY = kte_pkg::TextCapacityDef
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 adv_i,
  input  wire kte_pkg::kte_item_t   item_i,
  input  wire logic [31:0]          timeout_i,
  output kte_pkg::kte_result_t      res_o
);
  import kte_pkg::*;

  localparam int unsigned LenW = $clog2(TEXT_CAPACITY + 1);
  localparam logic [LenW:0] CapSum = (LenW + 1)'(TEXT_CAPACITY);

  logic            pend_q, pend_d;
  logic [3:0]      digit_q, digit_d;
  logic [1:0]      tidx_q, tidx_d;
  logic [31:0]     ttime_q, ttime_d;
  mode_e           mode_q, mode_d;
  logic [LenW-1:0] len_q, len_d;

  logic        do_commit;
  logic        extra;
  logic [7:0]  extra_ch;
  logic [7:0]  commit_ch;
  logic [31:0] diff;
  logic        in_time;
  logic        erase;
  logic [1:0]  app_n;
  logic [LenW:0] len_sum;
  logic [2:0]  next_idx;

  always_comb begin
    pend_d    = pend_q;
    digit_d   = digit_q;
    tidx_d    = tidx_q;
    ttime_d   = ttime_q;
    mode_d    = mode_q;
    do_commit = 1'b0;
    extra     = 1'b0;
    extra_ch  = 8'h00;
    erase     = 1'b0;
    diff      = item_i.tick_now - ttime_q;
    in_time   = (diff <= timeout_i);
    commit_ch = kte_letter(digit_q, tidx_q, mode_q == MODE_UPPER);
    next_idx  = {1'b0, tidx_q} + 3'd1;

    if (item_i.req_type == REQ_TIMEOUT) begin
      do_commit = pend_q && !in_time;
    end else if (item_i.key_code == KEY_BKSP) begin
      if (pend_q) begin
        pend_d = 1'b0;
        tidx_d = 2'd0;
      end else begin
        erase = (len_q != '0);
      end
    end else if (item_i.key_code == KEY_CASE) begin
      do_commit = pend_q;
      case (mode_q)
        MODE_UPPER: mode_d = MODE_LOWER;
        MODE_LOWER: mode_d = MODE_NUM;
        default:    mode_d = MODE_UPPER;
      endcase
    end else if (item_i.key_code == KEY_RETURN) begin
      do_commit = pend_q;
      extra     = 1'b1;
      extra_ch  = ChNewline;
    end else if (item_i.key_code == KEY_ASTERISK) begin
      do_commit = pend_q;
      extra     = 1'b1;
      extra_ch  = ChStar;
    end else if (item_i.key_code == KEY_POUND) begin
      do_commit = pend_q;
      extra     = 1'b1;
      extra_ch  = ChHash;
    end else if (item_i.key_code <= 4'd9) begin
      if (mode_q == MODE_NUM) begin
        do_commit = pend_q;
        extra     = 1'b1;
        extra_ch  = ChZero + {4'd0, item_i.key_code};
      end else if (item_i.key_code == 4'd0) begin
        do_commit = pend_q;
        extra     = 1'b1;
        extra_ch  = ChSpace;
      end else if (item_i.key_code == 4'd1) begin
        do_commit = pend_q;
        extra     = 1'b1;
        extra_ch  = ChOne;
      end else if (pend_q && digit_q == item_i.key_code && in_time) begin
        tidx_d  = (next_idx >= kte_count(item_i.key_code)) ? 2'd0 : next_idx[1:0];
        ttime_d = item_i.tick_now;
      end else begin
        do_commit = pend_q;
      end
    end

    if (do_commit) begin
      pend_d  = 1'b0;
      tidx_d  = 2'd0;
      ttime_d = 32'd0;
    end
    // fresh letter key press: start a new pending letter
    if (item_i.req_type == REQ_KEY && item_i.key_code <= 4'd9 && item_i.key_code >= 4'd2 &&
        mode_q != MODE_NUM && !(pend_q && digit_q == item_i.key_code && in_time)) begin
      pend_d  = 1'b1;
      digit_d = item_i.key_code;
      tidx_d  = 2'd0;
      ttime_d = item_i.tick_now;
    end

    app_n   = {1'b0, do_commit} + {1'b0, extra};
    len_sum = {1'b0, len_q} + (LenW + 1)'(app_n);
    if (erase) begin
      len_d = len_q - LenW'(1);
    end else if (len_sum > CapSum) begin
      len_d = LenW'(TEXT_CAPACITY);
    end else begin
      len_d = len_sum[LenW-1:0];
    end
  end

  always_comb begin
    res_o.append_count  = app_n;
    res_o.first_char    = do_commit ? commit_ch : (extra ? extra_ch : 8'h00);
    res_o.second_char   = (do_commit && extra) ? extra_ch : 8'h00;
    res_o.erase_last    = erase;
    res_o.pending_valid = pend_d;
    res_o.pending_char  = pend_d ? kte_letter(digit_d, tidx_d, mode_d == MODE_UPPER) : 8'h00;
    res_o.input_mode    = mode_d;
    res_o.text_length   = 8'(len_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q  <= 1'b0;
      digit_q <= 4'd0;
      tidx_q  <= 2'd0;
      ttime_q <= 32'd0;
      mode_q  <= MODE_UPPER;
      len_q   <= '0;
    end else if (adv_i) begin
      pend_q  <= pend_d;
      digit_q <= digit_d;
      tidx_q  <= tidx_d;
      ttime_q <= ttime_d;
      mode_q  <= mode_d;
      len_q   <= len_d;
    end
  end

endmodule

`default_nettype wire
